// File: sv/sacf_pkg.sv
// ---------------------------------------------------------------------------
// sacf_pkg: shared constants for the set-associative FIFO cache unit
// Access kinds, lookup outcomes, register indexes and field widths.
// ---------------------------------------------------------------------------
package sacf_pkg;

  localparam int ADDR_W     = 64;
  localparam int CNT_W      = 32;
  localparam int MODE_W     = 2;
  localparam int OUTCOME_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int SB_W       = 4;  // clamped set-index bit count, up to 7
  localparam int WAYS_W     = 5;  // clamped way count, up to 15

  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;

  localparam logic [MODE_W-1:0] MODE_FETCH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STORE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd3;

  localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_MISS  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

endpackage

// File: sv/sacf_if.sv
// ---------------------------------------------------------------------------
// sacf_if: valid/ready channels of the cache unit
// Access channel (mode, address) and lookup result channel.
// ---------------------------------------------------------------------------
interface sacf_in_if;
  logic                          valid;
  logic                          ready;
  logic [sacf_pkg::MODE_W-1:0]   mode;
  logic [sacf_pkg::ADDR_W-1:0]   address;

  modport source (output valid, mode, address, input ready);
  modport sink   (input valid, mode, address, output ready);
endinterface

interface sacf_out_if;
  logic                            valid;
  logic                            ready;
  logic [sacf_pkg::OUTCOME_W-1:0]  outcome;
  logic                            last_of_access;
  logic [sacf_pkg::CNT_W-1:0]      hit_total;
  logic [sacf_pkg::CNT_W-1:0]      miss_total;
  logic [sacf_pkg::CNT_W-1:0]      eviction_total;

  modport source (output valid, outcome, last_of_access, hit_total, miss_total,
                  eviction_total, input ready);
  modport sink   (input valid, outcome, last_of_access, hit_total, miss_total,
                  eviction_total, output ready);
endinterface

// File: sv/sacf_geom.sv
// ---------------------------------------------------------------------------
// sacf_geom: address split and geometry clamping
// Splits an address into set index and tag, and clamps the way count.
// ---------------------------------------------------------------------------
module sacf_geom #(
  parameter int MAX_SET_BITS = sacf_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = sacf_pkg::DEF_MAX_WAYS,
  localparam int SET_W       = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  logic [2:0]                    set_index_bits,
  input  logic [5:0]                    block_offset_bits,
  input  logic [3:0]                    ways_in_use,
  input  logic [sacf_pkg::ADDR_W-1:0]   address,
  output logic [SET_W-1:0]              set_idx,
  output logic [sacf_pkg::ADDR_W-1:0]   tag,
  output logic [sacf_pkg::WAYS_W-1:0]   ways
);

  logic [sacf_pkg::SB_W-1:0]     sb;
  logic [sacf_pkg::ADDR_W-1:0]   shifted;
  logic [SET_W-1:0]              mask;
  logic [6:0]                    tag_shift;
  logic [sacf_pkg::WAYS_W-1:0]   w_raw;

  always_comb begin
    if ({1'b0, set_index_bits} > sacf_pkg::SB_W'(MAX_SET_BITS)) begin
      sb = sacf_pkg::SB_W'(MAX_SET_BITS);
    end else begin
      sb = {1'b0, set_index_bits};
    end
    shifted   = address >> block_offset_bits;
    mask      = ~({SET_W{1'b1}} << sb);
    set_idx   = shifted[SET_W-1:0] & mask;
    tag_shift = {1'b0, block_offset_bits} + {3'b000, sb};
    if (tag_shift >= 7'd64) begin
      tag = '0;
    end else begin
      tag = address >> tag_shift;
    end
    w_raw = {1'b0, ways_in_use};
    if (w_raw == '0) begin
      ways = sacf_pkg::WAYS_W'(1);
    end else if (w_raw > sacf_pkg::WAYS_W'(MAX_WAYS)) begin
      ways = sacf_pkg::WAYS_W'(MAX_WAYS);
    end else begin
      ways = w_raw;
    end
  end

endmodule

// File: sv/set_assoc_cache_fifo_unit.sv
// ---------------------------------------------------------------------------
// set_assoc_cache_fifo_unit: tag-only set-associative cache, FIFO replacement
// Looks up each access, fills or evicts, and keeps hit/miss/eviction totals.
// ---------------------------------------------------------------------------
// Each set lives in one row of a tag memory (tags, line valid bits, FIFO
// slots and tail). A lookup is a read-modify-write of that row: it is read
// on the edge that takes the access and written back with the result from
// ST_EVAL, so a load or store makes one lookup, a modify two (the second
// re-reads the row it just wrote), and an instruction fetch none. A result
// waiting in the output register stalls the write-back cycle only. Rows are
// flagged untouched by reset through one flop per set, so the block takes
// accesses straight out of reset with no clearing pass. Configuration is to be
// written between accesses by the user; the block does not enforce it.
// ---------------------------------------------------------------------------
module set_assoc_cache_fifo_unit #(
  parameter int MAX_SET_BITS = sacf_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = sacf_pkg::DEF_MAX_WAYS
) (
  input  logic                               clk,
  input  logic                               rst,
  sacf_in_if.sink                            in,
  sacf_out_if.source                         out,
  input  logic                               cfg_we,
  input  logic [sacf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sacf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NSETS = 2 ** MAX_SET_BITS;
  localparam int OW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WW    = sacf_pkg::WAYS_W;
  localparam int PW    = 2 * WW;

  typedef struct packed {
    logic [MAX_WAYS-1:0]                            vld;
    logic [MAX_WAYS-1:0][sacf_pkg::ADDR_W-1:0]      tag;
    logic [MAX_WAYS-1:0][OW-1:0]                    ord;
    logic [OW-1:0]                                  tail;
    logic                                           used;
  } row_t;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EVAL} state_t;

  // configuration
  logic [2:0] set_index_bits;
  logic [5:0] block_offset_bits;
  logic [3:0] ways_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits    <= 3'd0;
      block_offset_bits <= 6'd0;
      ways_in_use       <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        sacf_pkg::CFG_SET_BITS:    set_index_bits    <= cfg_data[2:0];
        sacf_pkg::CFG_OFFSET_BITS: block_offset_bits <= cfg_data[5:0];
        sacf_pkg::CFG_WAYS:        ways_in_use       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic [SET_W-1:0]              g_set;
  logic [sacf_pkg::ADDR_W-1:0]   g_tag;
  logic [WW-1:0]                 ways;

  sacf_geom #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_geom (
    .set_index_bits    (set_index_bits),
    .block_offset_bits (block_offset_bits),
    .ways_in_use       (ways_in_use),
    .address           (in.address),
    .set_idx           (g_set),
    .tag               (g_tag),
    .ways              (ways)
  );

  state_t                        state;
  logic                          pend;
  logic [SET_W-1:0]              acc_set;
  logic [sacf_pkg::ADDR_W-1:0]   acc_tag;
  logic                          commit;
  logic                          in_xfer;

  logic                          out_vld;
  logic [sacf_pkg::OUTCOME_W-1:0] out_outcome;
  logic                          out_last;
  logic [sacf_pkg::CNT_W-1:0]    hit_count;
  logic [sacf_pkg::CNT_W-1:0]    miss_count;
  logic [sacf_pkg::CNT_W-1:0]    eviction_count;

  assign in.ready           = (state == ST_IDLE);
  assign in_xfer            = in.valid && in.ready;
  assign commit             = (state == ST_EVAL) && (!out_vld || out.ready);
  assign out.valid          = out_vld;
  assign out.outcome        = out_outcome;
  assign out.last_of_access = out_last;
  assign out.hit_total      = hit_count;
  assign out.miss_total     = miss_count;
  assign out.eviction_total = eviction_count;

  // tag memory and per-set touched flags
  row_t                mem [NSETS];
  logic [NSETS-1:0]    row_ok;
  row_t                rd_row;
  logic                rd_rv;
  row_t                new_row;
  logic [SET_W-1:0]    rd_addr;

  assign rd_addr = (state == ST_IDLE) ? g_set : acc_set;

  always_ff @(posedge clk) begin
    rd_row <= mem[rd_addr];
    if (commit) begin
      mem[acc_set] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
      rd_rv  <= 1'b0;
    end else begin
      rd_rv <= row_ok[rd_addr];
      if (commit) begin
        row_ok[acc_set] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      acc_set <= g_set;
      acc_tag <= g_tag;
    end
  end

  // lookup and row update
  logic [MAX_WAYS-1:0]           vld_e;
  logic                          used_e;
  logic                          hit;
  logic                          free_f;
  logic [OW-1:0]                 free_idx;
  logic [OW:0]                   tail_inc;
  logic [OW-1:0]                 tail_mod;
  logic [OW-1:0]                 tail_n;
  logic [OW-1:0]                 victim;
  logic [PW-1:0]                 prod;
  logic [sacf_pkg::OUTCOME_W-1:0] outcome_c;

  always_comb begin
    vld_e    = rd_rv ? rd_row.vld : '0;
    used_e   = rd_rv & rd_row.used;
    hit      = 1'b0;
    free_f   = 1'b0;
    free_idx = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WW'(i) < ways && vld_e[i] && rd_row.tag[i] == acc_tag) begin
        hit = 1'b1;
      end
    end
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (WW'(i) < ways && !vld_e[i]) begin
        free_f   = 1'b1;
        free_idx = OW'(i);
      end
    end
    // (tail + 1) mod ways: largest multiple of ways not above tail + 1
    tail_inc = {1'b0, rd_row.tail} + {{OW{1'b0}}, 1'b1};
    tail_mod = '0;
    prod     = '0;
    for (int q = 0; q <= MAX_WAYS; q++) begin
      prod = PW'(q) * PW'(ways);
      if (PW'(tail_inc) >= prod) begin
        tail_mod = OW'(PW'(tail_inc) - prod);
      end
    end
    tail_n = used_e ? tail_mod : '0;
    victim = rd_row.ord[tail_n];

    new_row      = rd_row;
    new_row.vld  = vld_e;
    new_row.used = used_e;
    if (hit) begin
      outcome_c = sacf_pkg::OUT_HIT;
    end else if (free_f) begin
      outcome_c               = sacf_pkg::OUT_MISS;
      new_row.tail            = tail_n;
      new_row.used            = 1'b1;
      new_row.ord[tail_n]     = free_idx;
      new_row.tag[free_idx]   = acc_tag;
      new_row.vld[free_idx]   = 1'b1;
    end else begin
      outcome_c    = sacf_pkg::OUT_EVICT;
      new_row.tail = tail_n;
      new_row.used = 1'b1;
      if (WW'(victim) < WW'(MAX_WAYS)) begin
        new_row.tag[victim] = acc_tag;
      end
    end
  end

  // control, totals and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pend           <= 1'b0;
      out_vld        <= 1'b0;
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
    end else begin
      if (commit) begin
        out_vld <= 1'b1;
      end else if (out.ready) begin
        out_vld <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer && in.mode != sacf_pkg::MODE_FETCH) begin
            pend  <= (in.mode == sacf_pkg::MODE_MODIFY);
            state <= ST_EVAL;
          end
        end
        ST_READ: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (commit) begin
            out_outcome <= outcome_c;
            if (outcome_c == sacf_pkg::OUT_HIT) begin
              hit_count <= hit_count + 32'd1;
            end else begin
              miss_count <= miss_count + 32'd1;
            end
            if (outcome_c == sacf_pkg::OUT_EVICT) begin
              eviction_count <= eviction_count + 32'd1;
            end
            if (pend) begin
              pend     <= 1'b0;
              out_last <= 1'b0;
              state    <= ST_READ;
            end else begin
              out_last <= 1'b1;
              state    <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_second_lookup: assert property (@(posedge clk) disable iff (rst)
    (commit && pend) |=> (state == ST_READ && out_vld && !out_last))
    else $error("modify did not return for its second lookup");

  a_one_count: assert property (@(posedge clk) disable iff (rst)
    commit |=> (hit_count + miss_count) == ($past(hit_count + miss_count) + 32'd1))
    else $error("lookup did not advance exactly one of hit or miss total");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !out.ready) |=> ($stable(hit_count) && $stable(miss_count) &&
                                 $stable(eviction_count)))
    else $error("totals moved while a result was stalled");

endmodule
